>>> hdl/pri_pkg.sv
// Shared types, constants and the reference-signal offset table of the PCFICH index generator.
package pri_pkg;

    localparam int unsigned CellW  = 9;
    localparam int unsigned NumRbW = 7;
    localparam int unsigned ReW    = 12;
    localparam int unsigned RemW   = 8;
    localparam int unsigned RsW    = 2;
    localparam int unsigned SeqW   = 4;
    localparam int unsigned DivCntW = 4;

    localparam logic [DivCntW-1:0] DivLast = DivCntW'(CellW - 1);
    localparam logic [SeqW-1:0]    SeqLast = '1;

    typedef struct packed {
        logic [CellW-1:0]  cell_id;
        logic [NumRbW-1:0] num_rb;
    } t_pri_req;

    typedef struct packed {
        logic [ReW-1:0] re_index;
        logic [1:0]     group_number;
        logic           is_last;
    } t_pri_res;

    typedef struct packed {
        logic [RemW-1:0]   rem;
        logic [NumRbW-1:0] num_rb;
        logic [RsW-1:0]    rs;
    } t_pri_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_pri_qstat;

    function automatic logic [2:0] pri_offset(input logic [RsW-1:0] rs, input logic [1:0] e);
        logic [2:0] v;
        v = 3'd0;
        case ({rs, e})
            4'b00_00: v = 3'd1;
            4'b00_01: v = 3'd2;
            4'b00_10: v = 3'd4;
            4'b00_11: v = 3'd5;
            4'b01_00: v = 3'd0;
            4'b01_01: v = 3'd2;
            4'b01_10: v = 3'd3;
            4'b01_11: v = 3'd5;
            4'b10_00: v = 3'd0;
            4'b10_01: v = 3'd1;
            4'b10_10: v = 3'd3;
            4'b10_11: v = 3'd4;
            default:  v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

>>> hdl/pri_front.sv
// Request intake: bit-serial remainder of cell id by twice the RB count, cell id mod three.
module pri_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  pri_pkg::t_pri_req  i_req,
    input  pri_pkg::t_pri_qstat i_qstat,
    output logic               o_push,
    output pri_pkg::t_pri_cmd  o_cmd
);
    import pri_pkg::*;

    localparam logic [1:0] StIdle = 2'd0;
    localparam logic [1:0] StDiv  = 2'd1;
    localparam logic [1:0] StDone = 2'd2;

    localparam int unsigned       Div3W     = CellW + 8;
    localparam int unsigned       Div3Shift = 9;
    localparam logic [Div3W-1:0]  Div3Mul   = Div3W'(171);

    logic [1:0]         r_state, n_state;
    logic [DivCntW-1:0] r_cnt, n_cnt;
    logic [CellW-1:0]   r_div, n_div;
    logic [RemW-1:0]    r_rem, n_rem;
    logic [RsW-1:0]     r_r3, n_r3;
    logic [NumRbW-1:0]  r_nrb, n_nrb;

    logic             accept;
    logic [RemW:0]    trial;
    logic [RemW-1:0]  modulus;
    logic [Div3W-1:0] div3_prod;
    logic [CellW-1:0] div3_quo;
    logic [CellW-1:0] div3_back;
    logic [RsW-1:0]   rem3;

    assign modulus = {r_nrb, 1'b0};
    assign trial   = {r_rem, r_div[CellW-1]};

    assign div3_prod = Div3W'(i_req.cell_id) * Div3Mul;
    assign div3_quo  = CellW'(div3_prod >> Div3Shift);
    assign div3_back = CellW'({div3_quo, 1'b0}) + div3_quo;
    assign rem3      = RsW'(i_req.cell_id - div3_back);

    assign busy   = (r_state == StDiv) || ((r_state == StDone) && i_qstat.full);
    assign accept = start && !busy;
    assign o_push = (r_state == StDone) && !i_qstat.full;
    assign o_cmd  = '{rem: r_rem, num_rb: r_nrb, rs: r_r3};

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_div   = r_div;
        n_rem   = r_rem;
        n_r3    = r_r3;
        n_nrb   = r_nrb;
        case (r_state)
            StDiv: begin
                n_div = {r_div[CellW-2:0], 1'b0};
                if (r_nrb == '0) begin
                    n_rem = '0;
                end else if (trial >= {1'b0, modulus}) begin
                    n_rem = RemW'(trial - {1'b0, modulus});
                end else begin
                    n_rem = trial[RemW-1:0];
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == DivLast) begin
                    n_state = StDone;
                end
            end
            StDone: begin
                if (o_push) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
        if (accept) begin
            n_state = StDiv;
            n_cnt   = '0;
            n_div   = i_req.cell_id;
            n_rem   = '0;
            n_r3    = rem3;
            n_nrb   = i_req.num_rb;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_div <= n_div;
        r_rem <= n_rem;
        r_r3  <= n_r3;
        r_nrb <= n_nrb;
    end

endmodule

>>> hdl/pri_queue.sv
// Small command queue between the intake and the index sequencer.
module pri_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    input  pri_pkg::t_pri_cmd   i_cmd,
    input  logic                i_pop,
    output pri_pkg::t_pri_cmd   o_cmd,
    output pri_pkg::t_pri_qstat o_qstat
);
    import pri_pkg::*;

    localparam int unsigned PtrW = $clog2(DEPTH);
    localparam int unsigned CntW = $clog2(DEPTH + 1);
    localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
    localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

    t_pri_cmd        r_mem [DEPTH];
    logic [PtrW-1:0] r_wr, r_rd;
    logic [CntW-1:0] r_cnt;
    logic            do_push, do_pop;

    assign o_qstat.full  = (r_cnt == CntFull);
    assign o_qstat.empty = (r_cnt == '0);
    assign do_push = i_push && !o_qstat.full;
    assign do_pop  = i_pop && !o_qstat.empty;
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == PtrLast) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == PtrLast) ? '0 : r_rd + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

>>> hdl/pri_back.sv
// Index sequencer: walks sixteen resource elements of one command, one per cycle.
module pri_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  pri_pkg::t_pri_cmd   i_cmd,
    input  pri_pkg::t_pri_qstat i_qstat,
    output logic                o_pop,
    output logic                o_valid,
    output pri_pkg::t_pri_res   o_res
);
    import pri_pkg::*;

    logic            r_active;
    logic [SeqW-1:0] r_seq;
    t_pri_cmd        r_cmd;
    logic            r_valid;
    t_pri_res        r_res;

    logic [1:0]        grp;
    logic [NumRbW+1:0] nrb3;
    logic [RemW-1:0]   half;
    logic [RemW:0]     k;
    logic [ReW-1:0]    k6;
    t_pri_res          n_res;

    assign o_pop = !i_qstat.empty && (!r_active || (r_seq == SeqLast));
    assign grp   = r_seq[3:2];
    assign nrb3  = {2'b00, r_cmd.num_rb} + {1'b0, r_cmd.num_rb, 1'b0};

    always_comb begin
        half = '0;
        case (grp)
            2'd0:    half = '0;
            2'd1:    half = RemW'(r_cmd.num_rb >> 1);
            2'd2:    half = RemW'(r_cmd.num_rb);
            2'd3:    half = nrb3[RemW:1];
            default: half = '0;
        endcase
    end

    assign k  = {1'b0, r_cmd.rem} + {1'b0, half};
    assign k6 = ReW'({k, 2'b00}) + ReW'({k, 1'b0});

    always_comb begin
        n_res.re_index     = k6 + ReW'(pri_offset(r_cmd.rs, r_seq[1:0]));
        n_res.group_number = grp;
        n_res.is_last      = (r_seq == SeqLast);
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_seq    <= '0;
            r_valid  <= 1'b0;
        end else begin
            r_valid <= r_active;
            if (o_pop) begin
                r_active <= 1'b1;
                r_seq    <= '0;
            end else if (r_active) begin
                if (r_seq == SeqLast) begin
                    r_active <= 1'b0;
                end
                r_seq <= r_seq + 1'b1;
            end
        end
        if (o_pop) begin
            r_cmd <= i_cmd;
        end
        r_res <= n_res;
    end

endmodule

>>> hdl/pcfich_re_index_generator_core.sv
// PCFICH resource element index generator, top level.
// Each request (cell id, RB count) yields sixteen subcarrier indices of symbol zero, one per
// cycle on o_valid, with no stall from the receiver. The intake computes a bit-serial
// remainder of the cell id by twice the RB count and then hands the command to a short
// queue; it takes the next request as it pushes the last one. The sequencer pops the next
// command from the queue as it walks the last index of the current one.
// busy is high while the intake divides and while it waits on a full queue.
module pcfich_re_index_generator_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  pri_pkg::t_pri_req i_req,
    output logic              o_valid,
    output pri_pkg::t_pri_res o_res
);
    import pri_pkg::*;

    t_pri_cmd   push_cmd, pop_cmd;
    t_pri_qstat qstat;
    logic       push, pop;

    pri_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    pri_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_cmd   (pop_cmd),
        .o_qstat (qstat)
    );

    pri_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (pop_cmd),
        .i_qstat (qstat),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

endmodule

>>> bench/tb.sv
// Self-checking testbench of the PCFICH resource element index generator.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pri_pkg::*;

    localparam int unsigned RbSubcarriers = 12;
    localparam int unsigned HalfRb        = 6;
    localparam int unsigned RsSpacing     = 3;
    localparam int unsigned RegSize       = 4;
    localparam int unsigned Groups        = 4;
    localparam int unsigned TailCycles    = 40;
    localparam int unsigned CycleLimit    = 200000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     start   = 1'b0;
    logic     busy;
    t_pri_req i_req   = '0;
    logic     o_valid;
    t_pri_res o_res;

    t_pri_res    re_expected[$];
    int unsigned mismatches = 0;
    int unsigned cycles     = 0;

    pcfich_re_index_generator_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_res   (o_res)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic void add_re_indices(input t_pri_req r);
        int unsigned cid;
        int unsigned nrb;
        int unsigned base;
        int unsigned rs;
        int unsigned grp_start;
        int unsigned rb_base;
        int unsigned q;
        int unsigned taken;
        int unsigned cnt;
        int unsigned g;
        t_pri_res    e;
        cid  = r.cell_id;
        nrb  = r.num_rb;
        base = (nrb != 0) ? HalfRb * (cid % (2 * nrb)) : 0;
        rs   = cid % RsSpacing;
        cnt  = 0;
        for (g = 0; g < Groups; g++) begin
            grp_start = base + ((g * nrb) / 2) * HalfRb;
            rb_base   = (grp_start / RbSubcarriers) * RbSubcarriers;
            taken     = 0;
            for (q = grp_start % RbSubcarriers; q < RbSubcarriers && taken < RegSize; q++) begin
                if (q % RsSpacing != rs) begin
                    e.re_index     = ReW'(rb_base + q);
                    e.group_number = 2'(g);
                    e.is_last      = (cnt == 15);
                    re_expected.push_back(e);
                    cnt++;
                    taken++;
                end
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (re_expected.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected index, expected none, actual %0d/%0d/%0d", $time,
                         o_res.re_index, o_res.group_number, o_res.is_last);
            end else begin
                if (o_res.re_index !== re_expected[0].re_index) begin
                    mismatches++;
                    $display("%0t: re_index expected %0d actual %0d", $time,
                             re_expected[0].re_index, o_res.re_index);
                end
                if (o_res.group_number !== re_expected[0].group_number) begin
                    mismatches++;
                    $display("%0t: group_number expected %0d actual %0d", $time,
                             re_expected[0].group_number, o_res.group_number);
                end
                if (o_res.is_last !== re_expected[0].is_last) begin
                    mismatches++;
                    $display("%0t: is_last expected %0d actual %0d", $time,
                             re_expected[0].is_last, o_res.is_last);
                end
                void'(re_expected.pop_front());
            end
        end
    end

    // hold start until the transaction is taken
    task automatic send_request(input logic [CellW-1:0] cell_num,
                                input logic [NumRbW-1:0] nrb);
        t_pri_req r;
        r.cell_id = cell_num;
        r.num_rb  = nrb;
        i_req <= r;
        start <= 1'b1;
        do @(posedge i_clk); while (busy);
        add_re_indices(r);
    endtask

    task automatic idle_cycles(input int unsigned n);
        if (n > 0) begin
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic drain_all();
        start <= 1'b0;
        while (re_expected.size() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);
    endtask

    task automatic test_field_extremes();
        send_request(9'd0, 7'd6);
        send_request(9'd503, 7'd110);
        send_request(9'd0, 7'd110);
        send_request(9'd503, 7'd6);
        idle_cycles(3);
        send_request(9'd1, 7'd25);
        idle_cycles(7);
        send_request(9'd2, 7'd50);
        send_request(9'd219, 7'd15);
        send_request(9'd220, 7'd75);
        send_request(9'd221, 7'd100);
    endtask

    task automatic test_zero_rb();
        send_request(9'd0, 7'd0);
        send_request(9'd511, 7'd0);
        send_request(9'd254, 7'd0);
    endtask

    task automatic test_out_of_range();
        send_request(9'd511, 7'd127);
        send_request(9'd510, 7'd1);
        send_request(9'd509, 7'd2);
        send_request(9'd257, 7'd64);
        send_request(9'd504, 7'd111);
        send_request(9'd0, 7'd127);
        send_request(9'd170, 7'd5);
        send_request(9'd341, 7'd3);
    endtask

    task automatic test_pause_until_empty();
        drain_all();
        send_request(9'd100, 7'd50);
        drain_all();
    endtask

    task automatic test_random_bursts(input int unsigned total);
        int unsigned sent;
        int unsigned burst;
        sent = 0;
        while (sent < total) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                if ($urandom_range(0, 9) < 8)
                    send_request(9'($urandom_range(0, 503)), 7'($urandom_range(6, 110)));
                else
                    send_request(9'($urandom_range(0, 511)), 7'($urandom_range(0, 127)));
                sent++;
            end
            case ($urandom_range(0, 3))
                0:       idle_cycles(0);
                1:       idle_cycles($urandom_range(1, 4));
                2:       idle_cycles($urandom_range(5, 40));
                default: idle_cycles($urandom_range(0, 16));
            endcase
            if ($urandom_range(0, 24) == 0)
                drain_all();
        end
    endtask

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_zero_rb();
        test_out_of_range();
        test_pause_until_empty();
        test_random_bursts(308);
        drain_all();
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> sim.f
hdl/pri_pkg.sv
hdl/pri_front.sv
hdl/pri_queue.sv
hdl/pri_back.sv
hdl/pcfich_re_index_generator_core.sv
bench/tb.sv
